>>> src/assert_macros.svh
// assertion macros shared by the interpolator rtl
// expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock outside reset
`define PLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pli_pkg.sv
// package for the piecewise linear interpolator
// table sizes, request and status codes; no dependencies
package pli_pkg;
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;
endpackage

>>> src/piecewise_linear_interpolator.sv
// clear, full insert and empty query go straight to S_FIN; an insert shifts larger entries
// up one slot per step from the table end; a query scans from the start, ends in a bounds
// status past the last point, and multiplies and divides when interpolating; one at a time
// the scan is bounded by the single read port of the breakpoint memory
// reset clears the point count and control; memory contents stay undefined
// depends on pli_pkg, pli_div and assert_macros.svh
`include "assert_macros.svh"
module piecewise_linear_interpolator import pli_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [1:0]               i_req_type,
    input  logic signed [DATA_W-1:0] i_point_x,
    input  logic signed [DATA_W-1:0] i_point_y,
    input  logic signed [DATA_W-1:0] i_query_x,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_result_y,
    output logic [1:0]               o_status,
    output logic [CNT_W-1:0]         o_points_held
);
    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_Q_RD, S_Q_CMP, S_MUL0, S_MUL1, S_DIV, S_FIN
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_k;
    logic signed [DATA_W-1:0] r_px, r_py, r_q;
    logic signed [DATA_W-1:0] r_prev_x, r_prev_y;
    logic [DATA_W-1:0]       r_mag, r_t, r_dx;
    logic                    r_neg;
    logic [2*DATA_W-1:0]     r_prod;
    logic signed [DATA_W-1:0] r_res;
    t_status                 r_stat;
    logic                    r_out_valid;
    logic signed [DATA_W-1:0] r_out_y;
    logic [1:0]              r_out_stat;
    logic [CNT_W-1:0]        r_out_cnt;

    logic [2*DATA_W-1:0]     mem [MAX_POINTS];
    logic [2*DATA_W-1:0]     r_rdata;
    logic                    we;
    logic [ADDR_W-1:0]       wa, ra;
    logic [2*DATA_W-1:0]     wd;

    logic signed [DATA_W-1:0] rd_x, rd_y;
    logic signed [DATA_W:0]  dy, tq, dxw;
    logic [DATA_W:0]         dy_abs;
    logic [DATA_W+DATA_W/2-1:0] pp_lo, pp_hi;
    logic [2*DATA_W-1:0]     dividend;
    logic                    div_start, div_done;
    logic [DATA_W-1:0]       div_quo;

    assign rd_x   = r_rdata[2*DATA_W-1:DATA_W];
    assign rd_y   = r_rdata[DATA_W-1:0];
    assign dy     = {rd_y[DATA_W-1], rd_y} - {r_prev_y[DATA_W-1], r_prev_y};
    assign tq     = {r_q[DATA_W-1], r_q} - {r_prev_x[DATA_W-1], r_prev_x};
    assign dxw    = {rd_x[DATA_W-1], rd_x} - {r_prev_x[DATA_W-1], r_prev_x};
    assign dy_abs = dy[DATA_W] ? -dy : dy;

    // product split into two 32x16 partials: the low one registered in S_MUL0, the high one added in S_MUL1
    assign pp_lo    = r_mag * r_t[DATA_W/2-1:0];
    assign pp_hi    = r_mag * r_t[DATA_W-1:DATA_W/2];
    assign dividend = r_prod + {pp_hi, {(DATA_W/2){1'b0}}};

    always_comb begin
        we = 1'b0;
        wa = r_k[ADDR_W-1:0];
        wd = {r_px, r_py};
        ra = r_k[ADDR_W-1:0];
        case (r_state)
            S_INS_RD: begin
                if (r_k == '0) we = 1'b1;
                else ra = ADDR_W'(r_k - 1'b1);
            end
            S_INS_CMP: begin
                we = 1'b1;
                if (rd_x > r_px) wd = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rdata <= mem[ra];
    end

    assign div_start = (r_state == S_MUL1);

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_dx),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_FIN)) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_px   <= i_point_x;
                        r_py   <= i_point_y;
                        r_q    <= i_query_x;
                        r_res  <= '0;
                        r_stat <= ST_OK;
                        r_state <= S_FIN;
                        case (t_req'(i_req_type))
                            REQ_CLEAR: r_count <= '0;
                            REQ_INSERT: begin
                                if (r_count >= CNT_W'(MAX_POINTS)) begin
                                    r_stat <= ST_FULL;
                                end else begin
                                    r_k     <= r_count;
                                    r_state <= S_INS_RD;
                                end
                            end
                            REQ_QUERY: begin
                                if (r_count == '0) begin
                                    r_stat <= ST_EMPTY;
                                end else begin
                                    r_k     <= '0;
                                    r_state <= S_Q_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (r_k == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    if (rd_x > r_px) begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_Q_RD: begin
                    if (r_k == r_count) begin
                        r_stat  <= ST_BOUNDS;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_Q_CMP;
                    end
                end
                S_Q_CMP: begin
                    if (r_q == rd_x) begin
                        r_res   <= rd_y;
                        r_state <= S_FIN;
                    end else if (r_q < rd_x) begin
                        if (r_k == '0) begin
                            r_stat  <= ST_BOUNDS;
                            r_state <= S_FIN;
                        end else begin
                            r_neg   <= dy[DATA_W];
                            r_mag   <= dy_abs[DATA_W-1:0];
                            r_t     <= tq[DATA_W-1:0];
                            r_dx    <= dxw[DATA_W-1:0];
                            r_state <= S_MUL0;
                        end
                    end else begin
                        r_prev_x <= rd_x;
                        r_prev_y <= rd_y;
                        r_k      <= r_k + 1'b1;
                        r_state  <= S_Q_RD;
                    end
                end
                S_MUL0: begin
                    r_prod  <= {{(DATA_W/2){1'b0}}, pp_lo};
                    r_state <= S_MUL1;
                end
                S_MUL1: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= r_neg ? r_prev_y - $signed(div_quo)
                                         : r_prev_y + $signed(div_quo);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_y     <= r_res;
                        r_out_stat  <= r_stat;
                        r_out_cnt   <= r_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_result_y    = r_out_y;
    assign o_status      = r_out_stat;
    assign o_points_held = r_out_cnt;

    `PLI_ASSERT(a_count_max, r_count <= CNT_W'(MAX_POINTS), "point count above table size")
    `PLI_ASSERT(a_count_step, (r_count == $past(r_count)) || (r_count == '0)
        || (r_count == $past(r_count) + 1'b1), "point count moved by more than one")
    `PLI_ASSERT_NEXT(a_div_ends, (r_state == S_DIV) && div_done, r_state == S_FIN,
        "quotient not taken")
endmodule

>>> src/pli_div.sv
// restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor
// depends on pli_pkg and assert_macros.svh
`include "assert_macros.svh"
module pli_div import pli_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*DATA_W-1:0]   i_dividend,
    input  logic [DATA_W-1:0]     i_divisor,
    output logic                  o_done,
    output logic [DATA_W-1:0]     o_quotient
);
    localparam int STEP_W = $clog2(2 * DATA_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [DATA_W:0]     r_rem;
    logic [2*DATA_W-1:0] r_dvd;
    logic [DATA_W-1:0]   r_dvs;
    logic [DATA_W:0]     rem_sh;
    logic                fits;

    assign rem_sh = {r_rem[DATA_W-1:0], r_dvd[2*DATA_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
                r_dvd  <= {r_dvd[2*DATA_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(2 * DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd[DATA_W-1:0];

    `PLI_ASSERT_NEXT(a_start_busy, i_start, r_busy, "divider did not start")
    `PLI_ASSERT(a_done_idle, !(r_done && r_busy), "divider done while busy")
    `PLI_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "divider done held")
endmodule

>>> test/tb_piecewise_linear_interpolator.sv
// self-checking testbench for the piecewise linear interpolator
// drives clear, insert, query and no-op requests, checks each result against a behavioral table
// depends on pli_pkg and the piecewise_linear_interpolator rtl
module tb_piecewise_linear_interpolator import pli_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qx;
    } t_request;

    typedef struct {
        logic signed [31:0] y;
        t_status            status;
        logic [CNT_W-1:0]   held;
    } t_answer;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [1:0]               i_req_type = REQ_NONE;
    logic signed [DATA_W-1:0] i_point_x = '0;
    logic signed [DATA_W-1:0] i_point_y = '0;
    logic signed [DATA_W-1:0] i_query_x = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b1;
    logic signed [DATA_W-1:0] o_result_y;
    logic [1:0]               o_status;
    logic [CNT_W-1:0]         o_points_held;

    t_request pending_requests[$];
    t_answer  expected_answers[$];
    longint   table_x[MAX_POINTS];
    longint   table_y[MAX_POINTS];
    int       table_count = 0;
    int       error_count = 0;
    int       tx_idle_pct = 7;
    int       rx_idle_pct = 73;
    int       queued_total = 0;
    logic     hold_arm = 1'b0;
    logic     hold_used = 1'b0;
    int       hold_left = 0;

    piecewise_linear_interpolator DUT (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_answer apply_request(logic [1:0] req, logic signed [31:0] px,
                                              logic signed [31:0] py, logic signed [31:0] qx);
        t_answer a;
        int pos;
        longint q, x0, y0, dy;
        logic [63:0] t, dx, mag, quo;
        a.y = '0;
        a.status = ST_OK;
        q = qx;
        case (req)
            REQ_CLEAR: table_count = 0;
            REQ_INSERT: begin
                if (table_count >= MAX_POINTS) begin
                    a.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < table_count && table_x[pos] <= longint'(px)) pos++;
                    for (int k = table_count; k > pos; k--) begin
                        table_x[k] = table_x[k-1];
                        table_y[k] = table_y[k-1];
                    end
                    table_x[pos] = px;
                    table_y[pos] = py;
                    table_count++;
                end
            end
            REQ_QUERY: begin
                if (table_count == 0) begin
                    a.status = ST_EMPTY;
                end else if (q < table_x[0] || q > table_x[table_count-1]) begin
                    a.status = ST_BOUNDS;
                end else begin
                    for (int i = 0; i < table_count; i++) begin
                        if (q == table_x[i]) begin
                            a.y = table_y[i][31:0];
                            break;
                        end
                        if (q < table_x[i] && i > 0) begin
                            x0 = table_x[i-1];
                            y0 = table_y[i-1];
                            dy = table_y[i] - y0;
                            t = q - x0;
                            dx = table_x[i] - x0;
                            mag = (dy < 0) ? -dy : dy;
                            if (dx == 0) begin
                                a.y = y0[31:0];
                            end else begin
                                quo = (mag * t) / dx;
                                a.y = (dy < 0) ? 32'(y0 - longint'(quo))
                                               : 32'(y0 + longint'(quo));
                            end
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        a.held = table_count[CNT_W-1:0];
        return a;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_requests
        t_request r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                expected_answers.push_back(apply_request(i_req_type, i_point_x, i_point_y,
                                                         i_query_x));
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    r = pending_requests.pop_front();
                    i_valid    <= 1'b1;
                    i_req_type <= r.req;
                    i_point_x  <= r.px;
                    i_point_y  <= r.py;
                    i_query_x  <= r.qx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_arm && !hold_used) begin
            hold_left <= 600;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= (hold_left > 1) || ($urandom_range(0, 99) < rx_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin : check_results
        t_answer e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result y=%0d status=%0d held=%0d", $realtime,
                         o_result_y, o_status, o_points_held);
                error_count++;
            end else begin
                e = expected_answers.pop_front();
                if (o_result_y !== e.y) begin
                    $display("%0t: result_y expected %0d actual %0d", $realtime, e.y,
                             o_result_y);
                    error_count++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                             o_status);
                    error_count++;
                end
                if (o_points_held !== e.held) begin
                    $display("%0t: points_held expected %0d actual %0d", $realtime, e.held,
                             o_points_held);
                    error_count++;
                end
            end
        end
    end

    function automatic void queue_request(logic [1:0] req, logic signed [31:0] px,
                                          logic signed [31:0] py, logic signed [31:0] qx);
        t_request r;
        r.req = req;
        r.px = px;
        r.py = py;
        r.qx = qx;
        pending_requests.push_back(r);
        queued_total++;
    endfunction

    function automatic logic signed [31:0] pick_between(longint lo, longint hi);
        logic [63:0] span;
        span = hi - lo + 1;
        return 32'(lo + longint'({$urandom, $urandom} % span));
    endfunction

    // one table build after a clear, followed by queries with an occasional no-op or insert
    function automatic void queue_table_session();
        int n, m;
        longint lo, hi;
        logic signed [31:0] xs[$];
        logic signed [31:0] px, base;
        queue_request(REQ_CLEAR, $urandom, $urandom, $urandom);
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
        base = $urandom;
        lo = 64'sh7fffffffffffffff;
        hi = -64'sh7fffffffffffffff;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: px = $urandom;
                1: px = (xs.size() > 0) ? xs[$urandom_range(0, xs.size() - 1)] : $urandom;
                default: px = 32'(base + $signed($urandom_range(0, 4000)) - 2000);
            endcase
            xs.push_back(px);
            if (px < lo) lo = px;
            if (px > hi) hi = px;
            queue_request(REQ_INSERT, px, $urandom, $urandom);
        end
        m = $urandom_range(2, 10);
        for (int i = 0; i < m; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: queue_request(REQ_QUERY, $urandom, $urandom,
                                       xs[$urandom_range(0, xs.size() - 1)]);
                3: queue_request(REQ_QUERY, $urandom, $urandom, $urandom);
                4: queue_request(REQ_NONE, $urandom, $urandom, $urandom);
                5: queue_request(REQ_INSERT, $urandom, $urandom, $urandom);
                default: queue_request(REQ_QUERY, $urandom, $urandom, pick_between(lo, hi));
            endcase
        end
    endfunction

    task automatic drain_all();
        while (pending_requests.size() > 0 || i_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h0);
        queue_request(REQ_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        queue_request(REQ_INSERT, 32'h80000000, 32'h7fffffff, 32'h0);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h80000000);
        queue_request(REQ_INSERT, 32'h7fffffff, 32'h80000000, 32'h0);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h0);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h7ffffffe);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h7fffffff);
        queue_request(REQ_INSERT, 32'h00010000, 32'h00050000, 32'h0);
        queue_request(REQ_INSERT, 32'h00010000, 32'h00090000, 32'h0);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h00010000);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h00008000);
        queue_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h0);
        queue_request(REQ_INSERT, 32'h00020000, 32'hfffe0000, 32'h0);
        queue_request(REQ_INSERT, 32'hfffe0000, 32'h00020000, 32'h0);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'hffff0000);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h00020001);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'hfffdffff);
        queue_request(REQ_QUERY, 32'h0, 32'h0, 32'h00000001);
        // fill past capacity
        queue_request(REQ_CLEAR, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < MAX_POINTS + 2; i++)
            queue_request(REQ_INSERT, $urandom, $urandom, $urandom);
        queue_request(REQ_QUERY, 32'h0, 32'h0, $urandom);

        while (queued_total < 600) queue_table_session();
        drain_all();

        tx_idle_pct = 73;
        rx_idle_pct = 7;
        while (queued_total < 1150) queue_table_session();
        drain_all();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_arm = 1'b1;
        while (queued_total < 1750) queue_table_session();
        drain_all();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
